FILE: rtl/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// Shared types and constants of the activation slice scheduler.
// ----------------------------------------------------------------------------
package asc_pkg;

    localparam int CNT_W   = 64;
    localparam int STEPS_W = 11;
    localparam int GRANT_W = 7;
    localparam int EXEC_W  = 12;
    localparam int CMD_W   = 2;

    localparam logic [STEPS_W-1:0] ACTIVATION_STEPS = STEPS_W'(1024);
    localparam logic [GRANT_W-1:0] SLICE_CAP        = GRANT_W'(64);

    localparam logic MODE_LEGACY   = 1'b0;
    localparam logic MODE_DEFERRED = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_REQUEST = 2'd0,
        CMD_BEGIN   = 2'd1,
        CMD_END     = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [EXEC_W-1:0] executed_steps;
        logic              hint;
        logic              fault;
    } t_item;

    typedef struct packed {
        logic               accepted;
        logic [GRANT_W-1:0] granted_steps;
        logic               busy_res;
    } t_result;

endpackage

FILE: rtl/asc_in_if.sv
// ----------------------------------------------------------------------------
// asc_in_if
// Command channel: valid/ready with one command item.
// ----------------------------------------------------------------------------
interface asc_in_if;
    import asc_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   cmd;
    logic [EXEC_W-1:0]  executed_steps;
    logic               hint;
    logic               fault;

    modport source (output valid, output cmd, output executed_steps, output hint,
                    output fault, input ready);
    modport sink   (input valid, input cmd, input executed_steps, input hint,
                    input fault, output ready);
endinterface

FILE: rtl/asc_out_if.sv
// ----------------------------------------------------------------------------
// asc_out_if
// Result channel: valid/ready with one result item.
// ----------------------------------------------------------------------------
interface asc_out_if;
    import asc_pkg::*;

    logic               valid;
    logic               ready;
    logic               accepted;
    logic [GRANT_W-1:0] granted_steps;
    logic               busy_res;

    modport source (output valid, output accepted, output granted_steps,
                    output busy_res, input ready);
    modport sink   (input valid, input accepted, input granted_steps,
                    input busy_res, output ready);
endinterface

FILE: rtl/asc_cfg_if.sv
// ----------------------------------------------------------------------------
// asc_cfg_if
// Configuration write channel carrying the mode register value.
// ----------------------------------------------------------------------------
interface asc_cfg_if;
    logic valid;
    logic ready;
    logic mode;

    modport source (output valid, output mode, input ready);
    modport sink   (input valid, input mode, output ready);
endinterface

FILE: rtl/asc_core.sv
// ----------------------------------------------------------------------------
// asc_core
// Scheduler state and the combinational command evaluation.
// ----------------------------------------------------------------------------
module asc_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_mode,
    input  asc_pkg::t_item    i_item,
    output asc_pkg::t_result  o_result
);
    import asc_pkg::*;

    logic [CNT_W-1:0]   r_act_cnt,   n_act_cnt;
    logic [CNT_W-1:0]   r_slice_cnt, n_slice_cnt;
    logic [STEPS_W-1:0] r_left,      n_left;
    logic               r_pend,      n_pend;
    logic               r_rearm,     n_rearm;

    logic [GRANT_W-1:0] quota;
    logic [CNT_W-1:0]   act_inc;
    logic               act_max;
    logic               slice_max;
    logic               ok;
    logic [GRANT_W-1:0] granted;

    logic               e_ok;
    logic [STEPS_W-1:0] e_left;
    logic               e_pend;
    logic               e_rearm;
    logic [CNT_W-1:0]   e_act;
    logic               e_abort;

    assign quota     = (r_left < STEPS_W'(SLICE_CAP)) ? r_left[GRANT_W-1:0] : SLICE_CAP;
    assign act_inc   = r_act_cnt + CNT_W'(1);
    assign act_max   = &r_act_cnt;
    assign slice_max = &r_slice_cnt;
    assign e_abort   = i_item.hint | i_item.fault;

    // end command: evaluate the candidate state, then qualify it
    always_comb begin
        e_ok    = r_pend
                  && (i_item.executed_steps <= EXEC_W'(quota))
                  && (e_abort || (i_item.executed_steps == EXEC_W'(quota)));
        e_left  = r_left;
        e_pend  = r_pend;
        e_rearm = r_rearm;
        e_act   = r_act_cnt;
        if (e_abort) begin
            e_left  = '0;
            e_pend  = 1'b0;
            e_rearm = 1'b0;
        end else begin
            e_left = r_left - i_item.executed_steps[STEPS_W-1:0];
            if (e_left == '0) begin
                if (r_rearm) begin
                    if (act_max) begin
                        e_ok = 1'b0;
                    end
                    e_act   = act_inc;
                    e_left  = ACTIVATION_STEPS;
                    e_rearm = 1'b0;
                end else begin
                    e_pend = 1'b0;
                end
            end
        end
        // no slice yet: only an immediate rearm back to the full budget passes
        if ((r_slice_cnt == '0) && (e_left != ACTIVATION_STEPS)) begin
            e_ok = 1'b0;
        end
    end

    always_comb begin
        n_act_cnt   = r_act_cnt;
        n_slice_cnt = r_slice_cnt;
        n_left      = r_left;
        n_pend      = r_pend;
        n_rearm     = r_rearm;
        ok          = 1'b0;
        granted     = '0;
        if (i_mode == MODE_DEFERRED) begin
            case (i_item.cmd)
                CMD_REQUEST: begin
                    if (r_pend) begin
                        n_rearm = 1'b1;
                        ok      = 1'b1;
                    end else if (!act_max) begin
                        n_act_cnt = act_inc;
                        n_left    = ACTIVATION_STEPS;
                        n_pend    = 1'b1;
                        ok        = 1'b1;
                    end
                end
                CMD_BEGIN: begin
                    if (r_pend && !slice_max) begin
                        n_slice_cnt = r_slice_cnt + CNT_W'(1);
                        granted     = quota;
                        ok          = 1'b1;
                    end
                end
                CMD_END: begin
                    if (e_ok) begin
                        n_act_cnt = e_act;
                        n_left    = e_left;
                        n_pend    = e_pend;
                        n_rearm   = e_rearm;
                        ok        = 1'b1;
                    end
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    assign o_result.accepted      = ok;
    assign o_result.granted_steps = granted;
    assign o_result.busy_res      = n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_cnt   <= '0;
            r_slice_cnt <= '0;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_rearm     <= 1'b0;
        end else if (i_fire) begin
            r_act_cnt   <= n_act_cnt;
            r_slice_cnt <= n_slice_cnt;
            r_left      <= n_left;
            r_pend      <= n_pend;
            r_rearm     <= n_rearm;
        end
    end

endmodule

FILE: rtl/activation_slice_scheduler.sv
// ----------------------------------------------------------------------------
// activation_slice_scheduler
// Hands out the step budget of deferred work activations in slices.
// ----------------------------------------------------------------------------
// One command is taken per cycle while the command channel is ready, and its
// result appears in the output register on the next cycle; a command is
// evaluated combinationally against the scheduler state (64-bit activation
// and slice counters, step budget, pending and rearm flags) and the state is
// updated on the same edge. The command channel stays ready while the output
// register is empty or its result is being taken, so back-to-back commands
// run at one per cycle. The mode register resets to the deferred slicing
// mode and is written through the configuration channel, which is always
// ready; write it only while no command is in flight.
module activation_slice_scheduler (
    input  logic     i_clk,
    input  logic     i_rst_n,
    asc_cfg_if.sink  i_cfg,
    asc_in_if.sink   i_in,
    asc_out_if.source o_out
);
    import asc_pkg::*;

    logic    r_mode;
    logic    r_out_valid;
    t_result r_result;

    t_item   item;
    t_result result;
    logic    fire;

    assign i_cfg.ready = 1'b1;

    assign item.cmd            = i_in.cmd;
    assign item.executed_steps = i_in.executed_steps;
    assign item.hint           = i_in.hint;
    assign item.fault          = i_in.fault;

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign fire       = i_in.valid && i_in.ready;

    asc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_mode   (r_mode),
        .i_item   (item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_DEFERRED;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.mode;
        end
    end

    // hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= result;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.accepted      = r_result.accepted;
    assign o_out.granted_steps = r_result.granted_steps;
    assign o_out.busy_res      = r_result.busy_res;

endmodule

FILE: tb/activation_slice_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// activation_slice_scheduler_tb
// Self-checking bench for the activation slice scheduler. A directed burst
// covers idle, refused and abort cases. Random phases then run mostly
// well-formed request/begin/end traffic with noise in between, and pass
// through legacy mode twice. Every result is checked against an in-bench
// model of the scheduler state, with random gaps on the command side and
// random stalls on the result side.
// ----------------------------------------------------------------------------
module activation_slice_scheduler_tb;
    import asc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [CNT_W-1:0]   act_cnt;
        logic [CNT_W-1:0]   slice_cnt;
        logic [STEPS_W-1:0] left;
        logic               pending;
        logic               rearm;
    } t_sched;

    logic clk;
    logic rst_n;

    asc_cfg_if cfg_if ();
    asc_in_if  cmd_if ();
    asc_out_if res_if ();

    activation_slice_scheduler uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_if),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    // Scheduler state as the block should hold it, and the copy used to shape stimulus
    t_sched  dut_state;
    logic    dut_mode;
    t_sched  plan_state;
    logic    plan_mode;

    t_item   cmd_backlog[$];
    t_result verdict_q[$];

    bit      cmd_fire;
    int      quiet_cycles;
    int      errors;
    int      n_cmds;
    int      n_taken;
    int      n_slices;
    int      n_results;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [STEPS_W-1:0] slice_quota(input logic [STEPS_W-1:0] left);
        return (left < STEPS_W'(SLICE_CAP)) ? left : STEPS_W'(SLICE_CAP);
    endfunction

    // Apply one command to the scheduler state and return the verdict it earns
    function automatic t_result schedule_cmd(inout t_sched st, input logic mode,
                                             input t_item it);
        t_sched             nx;
        logic               ok;
        logic [GRANT_W-1:0] grant;
        logic [STEPS_W-1:0] quota;
        t_result            r;
        nx    = st;
        ok    = 1'b0;
        grant = '0;
        quota = slice_quota(st.left);
        if (mode == MODE_DEFERRED) begin
            case (it.cmd)
                CMD_REQUEST: begin
                    if (st.pending) begin
                        nx.rearm = 1'b1;
                        ok = 1'b1;
                    end else if (st.act_cnt != '1) begin
                        nx.act_cnt = st.act_cnt + 1'b1;
                        nx.left    = ACTIVATION_STEPS;
                        nx.pending = 1'b1;
                        ok = 1'b1;
                    end
                end
                CMD_BEGIN: begin
                    if (st.pending && st.slice_cnt != '1) begin
                        nx.slice_cnt = st.slice_cnt + 1'b1;
                        grant = quota[GRANT_W-1:0];
                        ok = 1'b1;
                    end
                end
                CMD_END: begin
                    if (st.pending && it.executed_steps <= EXEC_W'(quota) &&
                        (it.hint || it.fault || it.executed_steps == EXEC_W'(quota))) begin
                        ok = 1'b1;
                        if (it.hint || it.fault) begin
                            nx.left    = '0;
                            nx.pending = 1'b0;
                            nx.rearm   = 1'b0;
                        end else begin
                            nx.left = st.left - it.executed_steps[STEPS_W-1:0];
                            if (nx.left == '0) begin
                                if (!st.rearm) begin
                                    nx.pending = 1'b0;
                                end else if (st.act_cnt == '1) begin
                                    ok = 1'b0;
                                end else begin
                                    nx.act_cnt = st.act_cnt + 1'b1;
                                    nx.left    = ACTIVATION_STEPS;
                                    nx.rearm   = 1'b0;
                                end
                            end
                        end
                        // no slice ever begun: only a fresh full budget may follow
                        if (st.slice_cnt == '0 && nx.left != ACTIVATION_STEPS)
                            ok = 1'b0;
                    end
                end
                default: ;
            endcase
        end
        if (ok)
            st = nx;
        r.accepted      = ok;
        r.granted_steps = grant;
        r.busy_res      = st.pending;
        return r;
    endfunction

    function automatic t_item make_cmd(input logic [CMD_W-1:0] c, input int unsigned steps,
                                       input logic h, input logic f);
        t_item it;
        it.cmd            = c;
        it.executed_steps = EXEC_W'(steps);
        it.hint           = h;
        it.fault          = f;
        return it;
    endfunction

    // Mostly well-formed traffic for the current state, with some noise and bad counts
    function automatic t_item pick_cmd(input t_sched st);
        t_item              it;
        int unsigned        roll;
        logic [STEPS_W-1:0] quota;
        logic [1:0]         abort_sel;
        roll  = $urandom_range(0, 99);
        quota = slice_quota(st.left);
        it    = '0;
        if (roll < 8) begin
            it.cmd            = CMD_W'($urandom_range(0, 3));
            it.executed_steps = EXEC_W'($urandom);
            it.hint           = 1'($urandom);
            it.fault          = 1'($urandom);
        end else if (!st.pending) begin
            if (roll < 85) begin
                it.cmd = CMD_REQUEST;
            end else if (roll < 92) begin
                it.cmd = CMD_BEGIN;
            end else begin
                it.cmd            = CMD_END;
                it.executed_steps = EXEC_W'(SLICE_CAP);
            end
        end else if (roll < 52) begin
            it.cmd = CMD_BEGIN;
        end else if (roll < 90) begin
            it.cmd            = CMD_END;
            it.executed_steps = EXEC_W'(quota);
        end else if (roll < 92) begin
            abort_sel         = 2'($urandom_range(1, 3));
            it.cmd            = CMD_END;
            it.executed_steps = EXEC_W'($urandom_range(0, quota));
            it.hint           = abort_sel[0];
            it.fault          = abort_sel[1];
        end else if (roll < 96) begin
            it.cmd = CMD_REQUEST;
        end else if (roll < 98) begin
            it.cmd            = CMD_END;
            it.executed_steps = EXEC_W'(quota + $urandom_range(1, 200));
            it.hint           = 1'($urandom);
        end else begin
            it.cmd            = CMD_END;
            it.executed_steps = EXEC_W'($urandom_range(0, quota - 1));
        end
        return it;
    endfunction

    task automatic queue_cmd(input t_item it);
        void'(schedule_cmd(plan_state, plan_mode, it));
        cmd_backlog.push_back(it);
    endtask

    task automatic queue_random(input int count);
        repeat (count) queue_cmd(pick_cmd(plan_state));
    endtask

    task automatic wait_idle();
        while (cmd_backlog.size() != 0 || verdict_q.size() != 0 || cmd_if.valid)
            @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.mode  <= m;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        plan_mode = m;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // Command driver: bursts of random length separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(negedge clk) begin
        t_item nxt;
        if (!rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_fire) begin
            if (gap_left != 0) begin
                cmd_if.valid <= 1'b0;
                gap_left--;
            end else if (cmd_backlog.size() != 0) begin
                nxt = cmd_backlog.pop_front();
                cmd_if.valid          <= 1'b1;
                cmd_if.cmd            <= nxt.cmd;
                cmd_if.executed_steps <= nxt.executed_steps;
                cmd_if.hint           <= nxt.hint;
                cmd_if.fault          <= nxt.fault;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Result-side stall pattern: always ready, rotating mask, or random density
    int unsigned stall_kind = 0;
    int unsigned stall_left = 0;
    int unsigned stall_pos  = 0;
    logic [7:0]  stall_mask = 8'hff;

    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_kind = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 80);
            stall_mask = 8'($urandom) | 8'h01;
        end
        stall_left--;
        stall_pos = (stall_pos + 1) % 8;
        case (stall_kind)
            0:       res_if.ready <= 1'b1;
            1:       res_if.ready <= stall_mask[stall_pos];
            2:       res_if.ready <= ($urandom_range(0, 1) == 0);
            default: res_if.ready <= ($urandom_range(0, 99) < 85);
        endcase
    end

    // Monitor: model every command transfer, check every result transfer
    always @(posedge clk) begin
        t_item   seen;
        t_result want;
        bit      moved;
        cmd_fire = 1'b0;
        if (!rst_n) begin
            dut_state = '0;
            dut_mode  = MODE_DEFERRED;
        end else begin
            moved = 1'b0;
            if (cfg_if.valid && cfg_if.ready) begin
                dut_mode = cfg_if.mode;
                moved = 1'b1;
            end
            if (cmd_if.valid && cmd_if.ready) begin
                seen.cmd            = cmd_if.cmd;
                seen.executed_steps = cmd_if.executed_steps;
                seen.hint           = cmd_if.hint;
                seen.fault          = cmd_if.fault;
                want = schedule_cmd(dut_state, dut_mode, seen);
                verdict_q.push_back(want);
                n_cmds++;
                if (want.accepted)
                    n_taken++;
                if (want.granted_steps != '0)
                    n_slices++;
                cmd_fire = 1'b1;
                moved = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                moved = 1'b1;
                n_results++;
                if (verdict_q.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    errors++;
                end else begin
                    want = verdict_q.pop_front();
                    if (res_if.accepted !== want.accepted) begin
                        $error("accepted: expected %0d, got %0d",
                               want.accepted, res_if.accepted);
                        errors++;
                    end
                    if (res_if.granted_steps !== want.granted_steps) begin
                        $error("granted_steps: expected %0d, got %0d",
                               want.granted_steps, res_if.granted_steps);
                        errors++;
                    end
                    if (res_if.busy_res !== want.busy_res) begin
                        $error("busy_res: expected %0d, got %0d",
                               want.busy_res, res_if.busy_res);
                        errors++;
                    end
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                         quiet_cycles, verdict_q.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        rst_n                 = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.mode           = MODE_DEFERRED;
        cmd_if.valid          = 1'b0;
        cmd_if.cmd            = CMD_REQUEST;
        cmd_if.executed_steps = '0;
        cmd_if.hint           = 1'b0;
        cmd_if.fault          = 1'b0;
        res_if.ready          = 1'b0;
        plan_state            = '0;
        plan_mode             = MODE_DEFERRED;
        quiet_cycles          = 0;
        errors                = 0;
        n_cmds                = 0;
        n_taken               = 0;
        n_slices              = 0;
        n_results             = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: idle refusals, end before any slice, bad counts, aborts
        queue_cmd(make_cmd(CMD_BEGIN,   0,    1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_END,     SLICE_CAP, 1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_UNUSED,  4095, 1'b1, 1'b1));
        queue_cmd(make_cmd(CMD_REQUEST, 0,    1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_END,     0,    1'b1, 1'b0));
        queue_cmd(make_cmd(CMD_END,     SLICE_CAP, 1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_END,     SLICE_CAP, 1'b0, 1'b1));
        queue_cmd(make_cmd(CMD_REQUEST, 0,    1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_BEGIN,   0,    1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_END,     SLICE_CAP + 1, 1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_END,     4095, 1'b1, 1'b0));
        queue_cmd(make_cmd(CMD_END,     10,   1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_END,     SLICE_CAP, 1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_BEGIN,   0,    1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_END,     0,    1'b1, 1'b0));
        queue_cmd(make_cmd(CMD_BEGIN,   0,    1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_REQUEST, 0,    1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_BEGIN,   0,    1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_END,     32,   1'b0, 1'b1));
        queue_cmd(make_cmd(CMD_REQUEST, 0,    1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_BEGIN,   0,    1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_END,     SLICE_CAP, 1'b1, 1'b1));
        queue_cmd(make_cmd(CMD_END,     SLICE_CAP, 1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_REQUEST, 0,    1'b0, 1'b0));
        queue_cmd(make_cmd(CMD_BEGIN,   0,    1'b0, 1'b0));
        wait_idle();

        set_mode(MODE_LEGACY);
        queue_random(40);
        wait_idle();
        set_mode(MODE_DEFERRED);
        queue_random(900);
        wait_idle();
        set_mode(MODE_LEGACY);
        queue_random(40);
        wait_idle();
        set_mode(MODE_DEFERRED);
        queue_random(900);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d commands (%0d accepted, %0d slices granted), %0d results.",
                 n_cmds, n_taken, n_slices, n_results);
        $display("Activations started: %0d, two legacy-mode windows, %0d errors.",
                 dut_state.act_cnt, errors);
        if (errors == 0 && verdict_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: activation_slice_scheduler.f
rtl/asc_pkg.sv
rtl/asc_in_if.sv
rtl/asc_out_if.sv
rtl/asc_cfg_if.sv
rtl/asc_core.sv
rtl/activation_slice_scheduler.sv
tb/activation_slice_scheduler_tb.sv
